>>> rtl/bphd_pkg.sv
// Package: item types, state record, phase codes and constants for the button detector.
package bphd_pkg;

  localparam int TIME_W = 32;
  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [TIME_W-1:0] TIMEOUT_SLACK = TIME_W'(5000);

  localparam logic LEVEL_LOW = 1'b0;
  localparam logic LEVEL_HIGH = 1'b1;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_DEB_PRESS = 2'd1;
  localparam logic [1:0] PH_CONFIRMED = 2'd2;
  localparam logic [1:0] PH_DEB_RELEASE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TIME = CFG_IDX_W'(1);

  localparam logic [CFG_W-1:0] DEBOUNCE_RESET = CFG_W'(20);

  typedef struct packed {
    logic              begin_req;
    logic              sample_level;
    logic              read_error;
    logic [TIME_W-1:0] now_ms;
  } bphd_in_t;

  typedef struct packed {
    logic finished;
    logic pressed;
    logic in_session;
  } bphd_out_t;

  typedef struct packed {
    logic              active;
    logic [1:0]        phase;
    logic [TIME_W-1:0] event_start;
    logic [TIME_W-1:0] confirm_time;
  } bphd_state_t;

endpackage

>>> rtl/bphd_step.sv
// Next-state and result logic for one sample of the button detector.
module bphd_step import bphd_pkg::*; (
  input  bphd_state_t       st,
  input  bphd_in_t          item,
  input  logic [CFG_W-1:0]  hold_time,
  input  logic [CFG_W-1:0]  debounce_time,
  output bphd_state_t       st_nxt,
  output bphd_out_t         res
);

  logic [TIME_W-1:0] el_event;
  logic [TIME_W-1:0] el_confirm;
  logic [TIME_W-1:0] el_timeout;
  logic [TIME_W-1:0] limit;
  logic [TIME_W-1:0] hold_w;
  logic [TIME_W-1:0] deb_w;
  logic              done;
  logic              fin;
  logic              prs;
  bphd_state_t       nxt;

  assign hold_w = TIME_W'(hold_time);
  assign deb_w = TIME_W'(debounce_time);
  assign limit = hold_w + deb_w + TIMEOUT_SLACK;
  assign el_event = item.now_ms - st.event_start;
  assign el_confirm = item.now_ms - st.confirm_time;

  always_comb begin
    nxt = st;
    done = 1'b0;
    fin = 1'b0;
    prs = 1'b0;
    el_timeout = '0;
    if (item.begin_req) begin
      nxt.active = 1'b1;
      nxt.phase = PH_IDLE;
      nxt.event_start = '0;
      nxt.confirm_time = '0;
      if (!item.read_error && item.sample_level == LEVEL_HIGH) begin
        nxt.active = 1'b0;
        fin = 1'b1;
      end
    end else if (st.active) begin
      if (item.read_error) begin
        done = 1'b1;
      end else begin
        case (st.phase)
          PH_IDLE: begin
            if (item.sample_level == LEVEL_LOW) begin
              nxt.phase = PH_DEB_PRESS;
              nxt.event_start = item.now_ms;
            end
          end
          PH_DEB_PRESS: begin
            if (item.sample_level == LEVEL_HIGH) begin
              nxt.phase = PH_IDLE;
            end else if (el_event >= deb_w) begin
              nxt.phase = PH_CONFIRMED;
              nxt.confirm_time = item.now_ms;
              if (hold_time == '0) begin
                done = 1'b1;
                prs = 1'b1;
              end
            end
          end
          PH_CONFIRMED: begin
            if (item.sample_level == LEVEL_HIGH) begin
              nxt.phase = PH_DEB_RELEASE;
              nxt.event_start = item.now_ms;
            end else if (el_confirm >= hold_w) begin
              done = 1'b1;
              prs = 1'b1;
            end
          end
          default: begin
            if (item.sample_level == LEVEL_LOW) begin
              nxt.phase = PH_CONFIRMED;
            end else if (el_event >= deb_w) begin
              done = 1'b1;
            end
          end
        endcase
        el_timeout = item.now_ms - nxt.event_start;
        if (!done && el_timeout > limit) begin
          done = 1'b1;
        end
      end
      if (done) begin
        nxt.active = 1'b0;
        fin = 1'b1;
      end
    end
  end

  assign st_nxt = nxt;
  assign res.finished = fin;
  assign res.pressed = fin & prs;
  assign res.in_session = nxt.active;

endmodule

>>> rtl/button_press_hold_detector.sv
// Top level of the button press and hold detector: input stage, state, result stage.
//
//   channel | ports                             | direction
//   input   | in_valid, in_ready, in_data       | sample items in
//   result  | out_valid, out_ready, out_data    | one result item per sample out
//   config  | cfg_valid, cfg_ready, cfg_index,  | register writes in
//           | cfg_data                          |
//
// One item per cycle sustained unless the result stage stalls.
// The sample passes an input register, the phase logic, then the result register.
// Sync active-low reset clears session state, valids and hold time; debounce gets 20.
// A stalled result stage holds the input stage; in_ready drops only when both are full.
// cfg_ready is always high.
module button_press_hold_detector import bphd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  bphd_in_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output bphd_out_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic             s1_valid_r;
  logic             s1_valid_nxt;
  bphd_in_t         s1_data_r;
  logic             out_valid_r;
  logic             out_valid_nxt;
  bphd_out_t        out_data_r;
  bphd_state_t      state_r;
  bphd_state_t      state_nxt;
  bphd_out_t        res;
  logic [CFG_W-1:0] hold_time_r;
  logic [CFG_W-1:0] debounce_time_r;
  logic             advance;
  logic             in_fire;

  bphd_step u_step (
    .st            (state_r),
    .item          (s1_data_r),
    .hold_time     (hold_time_r),
    .debounce_time (debounce_time_r),
    .st_nxt        (state_nxt),
    .res           (res)
  );

  assign advance = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;
  assign in_fire = in_valid && in_ready;
  assign s1_valid_nxt = in_fire || (s1_valid_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && !out_ready);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      state_r <= '0;
      hold_time_r <= '0;
      debounce_time_r <= DEBOUNCE_RESET;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        state_r <= state_nxt;
      end
      if (cfg_valid) begin
        case (cfg_index)
          CFG_HOLD_TIME: hold_time_r <= cfg_data;
          CFG_DEBOUNCE_TIME: debounce_time_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

`ifndef SYNTHESIS
  a_press_needs_finish: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_data_r.pressed || out_data_r.finished))
    else $error("pressed without finished");

  a_finish_ends_session: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && res.finished) |=> !state_r.active)
    else $error("session still active after finish");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r && !out_ready))
    else $error("input stalled while a stage is free");

  a_session_flag_matches: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> (out_data_r.in_session == state_r.active))
    else $error("in_session disagrees with session state");
`endif

endmodule

>>> test/tb_button_press_hold_detector.sv
// Testbench for the button press and hold detector: directed and random samples, scoreboard.
`timescale 1ns / 100ps

module tb_button_press_hold_detector;
  import bphd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(3);

  class press_hold_board;
    logic [CFG_W-1:0]  hold_ms;
    logic [CFG_W-1:0]  stable_len;
    logic              active;
    logic [1:0]        phase;
    logic [TIME_W-1:0] event_start;
    logic [TIME_W-1:0] confirm_at;
    bphd_out_t         pending_q[$];
    int                errors;

    function new();
      hold_ms = '0;
      stable_len = DEBOUNCE_RESET;
      active = 1'b0;
      phase = PH_IDLE;
      event_start = '0;
      confirm_at = '0;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      if (idx == CFG_HOLD_TIME) begin
        hold_ms = val;
      end else if (idx == CFG_DEBOUNCE_TIME) begin
        stable_len = val;
      end
    endfunction

    function logic [TIME_W-1:0] since(logic [TIME_W-1:0] now, logic [TIME_W-1:0] mark);
      return now - mark;
    endfunction

    // Advance the detector by one sample, queue its result; return 1 if the sample was not ignored.
    function bit note_input(bphd_in_t s);
      bphd_out_t         r;
      logic              done;
      logic [TIME_W-1:0] lim;
      bit                busy;
      r = '0;
      done = 1'b0;
      busy = s.begin_req || active;
      lim = TIME_W'(hold_ms) + TIME_W'(stable_len) + TIMEOUT_SLACK;
      if (s.begin_req) begin
        active = 1'b1;
        phase = PH_IDLE;
        event_start = '0;
        confirm_at = '0;
        if (!s.read_error && s.sample_level == LEVEL_HIGH) begin
          active = 1'b0;
          r.finished = 1'b1;
        end
      end else if (active) begin
        if (s.read_error) begin
          done = 1'b1;
        end else begin
          case (phase)
            PH_IDLE: begin
              if (s.sample_level == LEVEL_LOW) begin
                phase = PH_DEB_PRESS;
                event_start = s.now_ms;
              end
            end
            PH_DEB_PRESS: begin
              if (s.sample_level == LEVEL_HIGH) begin
                phase = PH_IDLE;
              end else if (since(s.now_ms, event_start) >= stable_len) begin
                phase = PH_CONFIRMED;
                confirm_at = s.now_ms;
                if (hold_ms == '0) begin
                  done = 1'b1;
                  r.pressed = 1'b1;
                end
              end
            end
            PH_CONFIRMED: begin
              if (s.sample_level == LEVEL_HIGH) begin
                phase = PH_DEB_RELEASE;
                event_start = s.now_ms;
              end else if (since(s.now_ms, confirm_at) >= hold_ms) begin
                done = 1'b1;
                r.pressed = 1'b1;
              end
            end
            default: begin
              if (s.sample_level == LEVEL_LOW) begin
                phase = PH_CONFIRMED;
              end else if (since(s.now_ms, event_start) >= stable_len) begin
                done = 1'b1;
              end
            end
          endcase
          if (!done && since(s.now_ms, event_start) > lim) begin
            done = 1'b1;
          end
        end
        if (done) begin
          active = 1'b0;
          r.finished = 1'b1;
        end
      end
      if (!r.finished) begin
        r.pressed = 1'b0;
      end
      r.in_session = active;
      pending_q.push_back(r);
      return busy;
    endfunction

    function void check_result(bphd_out_t got);
      bphd_out_t want;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result finished=%b pressed=%b in_session=%b",
                 $time, got.finished, got.pressed, got.in_session);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (got !== want) begin
        $display({"%0t: mismatch finished exp %b got %b, pressed exp %b got %b, ",
                  "in_session exp %b got %b"},
                 $time, want.finished, got.finished, want.pressed, got.pressed,
                 want.in_session, got.in_session);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  bphd_in_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  bphd_out_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  press_hold_board board;
  bit              calm;
  int              busy_items;

  button_press_hold_detector dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("tb_button_press_hold_detector: errors");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else if (r < 98) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  initial begin
    int stall;
    stall = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        stall = pick_gap();
      end
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        board.check_result(out_data);
      end
    end
  end

  task automatic send_sample(bphd_in_t s);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= s;
    do @(posedge clk); while (!in_ready);
    if (board.note_input(s)) begin
      busy_items++;
    end
    @(negedge clk);
  endtask

  task automatic sample(logic b, logic l, logic e, logic [TIME_W-1:0] t);
    bphd_in_t s;
    s.begin_req = b;
    s.sample_level = l;
    s.read_error = e;
    s.now_ms = t;
    send_sample(s);
  endtask

  // Drop valid and wait until every expected result has drained.
  task automatic settle();
    in_valid <= 1'b0;
    while (board.pending_q.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic run_session();
    logic [TIME_W-1:0] t;
    int                scale;
    int                lim;
    int                n;
    int                rel_at;
    int                k;
    bphd_in_t          s;
    scale = (int'(board.hold_ms) + int'(board.stable_len)) / 6 + 2;
    lim = int'(board.hold_ms) + int'(board.stable_len) + 5000;
    k = $urandom_range(0, 9);
    if (k < 6) begin
      t = $urandom;
    end else if (k < 8) begin
      t = $urandom_range(0, 300);
    end else begin
      t = {TIME_W{1'b1}} - TIME_W'($urandom_range(0, 4 * scale));
    end
    k = $urandom_range(0, 19);
    s.begin_req = 1'b1;
    s.read_error = (k == 0 || k == 2);
    s.sample_level = (k <= 1) ? LEVEL_HIGH : LEVEL_LOW;
    s.now_ms = $urandom;
    send_sample(s);
    n = $urandom_range(3, 30);
    rel_at = $urandom_range(2, n);
    for (int i = 0; i < n && board.active; i++) begin
      k = $urandom_range(0, 99);
      t += (k < 4) ? TIME_W'($urandom_range(scale, lim + scale))
                   : TIME_W'($urandom_range(0, scale));
      s.begin_req = 1'b0;
      s.now_ms = t;
      s.read_error = ($urandom_range(0, 49) == 0);
      if (i < 3) begin
        s.sample_level = 1'($urandom_range(0, 1));
      end else if (i < rel_at) begin
        s.sample_level = ($urandom_range(0, 9) == 0) ? LEVEL_HIGH : LEVEL_LOW;
      end else begin
        s.sample_level = ($urandom_range(0, 6) == 0) ? LEVEL_LOW : LEVEL_HIGH;
      end
      send_sample(s);
    end
  endtask

  task automatic run_noise();
    bphd_in_t s;
    int       n;
    n = $urandom_range(1, 5);
    repeat (n) begin
      s.begin_req = ($urandom_range(0, 4) == 0);
      s.sample_level = 1'($urandom_range(0, 1));
      s.read_error = ($urandom_range(0, 9) == 0);
      s.now_ms = $urandom;
      send_sample(s);
    end
  endtask

  initial begin
    logic [CFG_W-1:0] h;
    logic [CFG_W-1:0] d;
    int               goal;
    board = new();
    calm = 1'b0;
    busy_items = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_HOLD_TIME;
    cfg_data = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    sample(1'b0, LEVEL_HIGH, 1'b0, 32'd7);
    sample(1'b1, LEVEL_HIGH, 1'b0, 32'd0);
    sample(1'b1, LEVEL_HIGH, 1'b1, 32'd0);
    sample(1'b1, LEVEL_LOW, 1'b0, 32'd100);
    sample(1'b0, LEVEL_HIGH, 1'b0, 32'd101);
    sample(1'b0, LEVEL_LOW, 1'b0, 32'd110);
    sample(1'b0, LEVEL_HIGH, 1'b0, 32'd115);
    sample(1'b0, LEVEL_LOW, 1'b0, 32'd120);
    sample(1'b0, LEVEL_LOW, 1'b0, 32'd140);
    sample(1'b1, LEVEL_LOW, 1'b0, 32'd0);
    sample(1'b0, LEVEL_LOW, 1'b0, 32'hFFFF_FFF8);
    sample(1'b0, LEVEL_LOW, 1'b0, 32'h0000_000C);
    sample(1'b1, LEVEL_LOW, 1'b0, 32'd500);
    sample(1'b0, LEVEL_LOW, 1'b1, 32'd505);
    sample(1'b1, LEVEL_LOW, 1'b0, 32'd0);
    sample(1'b0, LEVEL_HIGH, 1'b0, 32'd5021);
    settle();
    write_reg(CFG_HOLD_TIME, CFG_W'(100));
    write_reg(CFG_DEBOUNCE_TIME, CFG_W'(10));
    sample(1'b1, LEVEL_LOW, 1'b0, 32'd0);
    sample(1'b0, LEVEL_LOW, 1'b0, 32'd1000);
    sample(1'b0, LEVEL_LOW, 1'b0, 32'd1010);
    sample(1'b0, LEVEL_HIGH, 1'b0, 32'd1050);
    sample(1'b0, LEVEL_LOW, 1'b0, 32'd1055);
    sample(1'b0, LEVEL_LOW, 1'b0, 32'd1110);
    sample(1'b1, LEVEL_LOW, 1'b0, 32'd0);
    sample(1'b0, LEVEL_LOW, 1'b0, 32'd2000);
    sample(1'b0, LEVEL_LOW, 1'b0, 32'd2010);
    sample(1'b0, LEVEL_HIGH, 1'b0, 32'd2020);
    sample(1'b0, LEVEL_HIGH, 1'b0, 32'd2030);

    busy_items = 0;
    for (int p = 0; p < 8; p++) begin
      settle();
      case (p)
        0: begin
          h = '0;
          d = '0;
        end
        1: begin
          h = '1;
          d = '1;
        end
        2: begin
          h = '0;
          d = '1;
        end
        3: begin
          h = '1;
          d = '0;
        end
        4: begin
          h = CFG_W'(50);
          d = CFG_W'(20);
        end
        5: begin
          h = CFG_W'($urandom_range(0, 300));
          d = CFG_W'($urandom_range(0, 60));
        end
        6: begin
          h = CFG_W'($urandom);
          d = CFG_W'($urandom);
        end
        default: begin
          h = CFG_W'(200);
          d = CFG_W'(5);
        end
      endcase
      write_reg(CFG_HOLD_TIME, h);
      write_reg(CFG_DEBOUNCE_TIME, d);
      if (p == 3) begin
        write_reg(CFG_SPARE_A, CFG_W'($urandom));
        write_reg(CFG_SPARE_B, CFG_W'($urandom));
      end
      calm = (p % 3 == 1);
      goal = (p + 1) * 1150 / 8;
      while (busy_items < goal) begin
        if ($urandom_range(0, 9) == 0) begin
          run_noise();
        end else begin
          run_session();
        end
      end
    end

    settle();
    repeat (10) @(negedge clk);
    if (board.errors == 0 && board.pending_q.size() == 0) begin
      $display("tb_button_press_hold_detector: clean");
    end else begin
      $display("tb_button_press_hold_detector: errors");
    end
    $finish;
  end

endmodule
